### sv/arithmetic_shift_with_flags_assert.svh
// ----------------------------------------------------------------------------
// Arithmetic shift with flags: assertion macros
// Concurrent assertion wrappers clocked on clock; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ARITHMETIC_SHIFT_WITH_FLAGS_ASSERT_SVH
`define ARITHMETIC_SHIFT_WITH_FLAGS_ASSERT_SVH

`ifndef SYNTH
`define ASF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ASF_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ASF_ASSERT(lbl, prop, msg)
`define ASF_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### sv/asf_pkg.sv
// ----------------------------------------------------------------------------
// Arithmetic shift with flags: package
// Word types, stage types and opcode field constants shared by all stages.
// ----------------------------------------------------------------------------
package asf_pkg;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_WORD = 2'd1;

   localparam int OP_DIR_BIT     = 8;
   localparam int OP_REG_CNT_BIT = 5;
   localparam int OP_CNT_LSB     = 9;
   localparam int OP_CNT_MSB     = 11;
   localparam int OP_DEST_MSB    = 2;

   localparam logic [5:0] CNT_IMM_ZERO = 6'd8;
   localparam logic [7:0] BASE_SHORT   = 8'd6;
   localparam logic [7:0] BASE_LONG    = 8'd8;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] opcode;
      logic [5:0]  count_register_low;
      logic [31:0] destination_value;
      logic        x_in;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic [2:0]  dest_index;
      logic        flag_x;
      logic        flag_n;
      logic        flag_z;
      logic        flag_v;
      logic        flag_c;
      logic [7:0]  cycles;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        left;
      logic [5:0]  cnt;
      logic        cnt_zero;
      logic        cnt_ge_w;
      logic [31:0] value;
      logic [31:0] mask;
      logic [31:0] topmask;
      logic [31:0] dst;
      logic [2:0]  dest_index;
      logic        x_in;
      logic [7:0]  cycles;
   } dec_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] result;
      logic        carry;
      logic        ovf;
      logic        cnt_zero;
      logic [31:0] mask;
      logic [31:0] dst;
      logic [2:0]  dest_index;
      logic        x_in;
      logic [7:0]  cycles;
   } shf_type;

endpackage

### sv/arithmetic_shift_with_flags.sv
// ----------------------------------------------------------------------------
// Arithmetic shift with flags
// Shifts the low byte, word or long of a data register left or right
// arithmetically and returns the new register value, flags and cycle cost.
//
// The req channel carries one instruction word per handshake: size, opcode,
// count register bits, destination contents and the incoming X flag. The rsp
// channel returns one word per instruction, in order: the new register value
// with the upper bits kept, the destination number, X, N, Z, V, C and the
// cycle cost. Both channels use valid and ready.
// A word accepted at a rising edge passes the decode, shift and flag
// register stages in that order, and rsp_valid rises once the word is held
// in the flag register. One word is accepted every cycle while the receiver
// takes words, since each stage takes a new word as it passes its last on.
// When rsp_ready is low, words stay in their stages and req_ready falls once
// all three stages hold a word; nothing is lost or repeated.
// Reset empties all three stages and holds rsp_valid low.
// ----------------------------------------------------------------------------
`include "arithmetic_shift_with_flags_assert.svh"

module arithmetic_shift_with_flags (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  asf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output asf_pkg::rsp_type rsp_data
);
   import asf_pkg::*;

   logic    dec_valid;
   logic    dec_ready;
   dec_type dec_data;
   logic    shf_valid;
   logic    shf_ready;
   shf_type shf_data;

   asf_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   asf_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (shf_valid),
      .out_ready (shf_ready),
      .out_data  (shf_data)
   );

   asf_flags u_flags (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (shf_valid),
      .in_ready  (shf_ready),
      .in_data   (shf_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   `ASF_ASSERT_RST(a_reset_empty, $past(reset) && !reset |-> !rsp_valid, "response valid right after reset")
   `ASF_ASSERT(a_full_rate, rsp_ready |-> req_ready, "input stalled while output drains")
   `ASF_ASSERT(a_zero_not_negative, rsp_valid && rsp_data.flag_z |-> !rsp_data.flag_n, "Z and N both set")

endmodule

### sv/asf_decode.sv
// ----------------------------------------------------------------------------
// Arithmetic shift with flags: decode stage
// Resolves the shift count, operand size, masks and cycle cost.
// ----------------------------------------------------------------------------
module asf_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  asf_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output asf_pkg::dec_type out_data
);
   import asf_pkg::*;

   logic       valid_ff;
   dec_type    data_ff;
   dec_type    data_in;
   logic [5:0] imm_cnt;
   logic [5:0] width;
   logic [6:0] cnt_plus;

   always_comb begin
      imm_cnt = {3'b000, in_data.opcode[OP_CNT_MSB:OP_CNT_LSB]};
      if (in_data.opcode[OP_REG_CNT_BIT]) begin
         data_in.cnt = in_data.count_register_low;
      end else if (imm_cnt == 6'd0) begin
         data_in.cnt = CNT_IMM_ZERO;
      end else begin
         data_in.cnt = imm_cnt;
      end
      case (in_data.kind)
         KIND_BYTE: begin
            width          = 6'd8;
            data_in.mask   = 32'h0000_00FF;
            data_in.cycles = BASE_SHORT + {1'b0, data_in.cnt, 1'b0};
         end
         KIND_WORD: begin
            width          = 6'd16;
            data_in.mask   = 32'h0000_FFFF;
            data_in.cycles = BASE_SHORT + {1'b0, data_in.cnt, 1'b0};
         end
         default: begin
            width          = 6'd32;
            data_in.mask   = 32'hFFFF_FFFF;
            data_in.cycles = BASE_LONG + {1'b0, data_in.cnt, 1'b0};
         end
      endcase
      cnt_plus           = {1'b0, data_in.cnt} + 7'd1;
      data_in.topmask    = data_in.mask & ~(data_in.mask >> cnt_plus);
      data_in.kind       = in_data.kind;
      data_in.left       = in_data.opcode[OP_DIR_BIT];
      data_in.cnt_zero   = (data_in.cnt == 6'd0);
      data_in.cnt_ge_w   = (data_in.cnt >= width);
      data_in.value      = in_data.destination_value & data_in.mask;
      data_in.dst        = in_data.destination_value;
      data_in.dest_index = in_data.opcode[OP_DEST_MSB:0];
      data_in.x_in       = in_data.x_in;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### sv/asf_shift.sv
// ----------------------------------------------------------------------------
// Arithmetic shift with flags: shift stage
// Barrel shift left or right with sign fill, last bit out and overflow.
// ----------------------------------------------------------------------------
`include "arithmetic_shift_with_flags_assert.svh"

module asf_shift (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  asf_pkg::dec_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output asf_pkg::shf_type out_data
);
   import asf_pkg::*;

   logic               valid_ff;
   shf_type            data_ff;
   shf_type            data_in;
   logic [31:0]        sext;
   logic signed [32:0] ext;
   logic [32:0]        rshift;
   logic [32:0]        lshift;
   logic [31:0]        top;
   logic               lcarry;

   always_comb begin
      case (in_data.kind)
         KIND_BYTE: begin
            sext   = {{24{in_data.value[7]}}, in_data.value[7:0]};
            lshift = {1'b0, in_data.value} << in_data.cnt;
            lcarry = lshift[8];
         end
         KIND_WORD: begin
            sext   = {{16{in_data.value[15]}}, in_data.value[15:0]};
            lshift = {1'b0, in_data.value} << in_data.cnt;
            lcarry = lshift[16];
         end
         default: begin
            sext   = in_data.value;
            lshift = {1'b0, in_data.value} << in_data.cnt;
            lcarry = lshift[32];
         end
      endcase
      ext    = $signed({sext, 1'b0});
      rshift = ext >>> in_data.cnt;
      top    = in_data.value & in_data.topmask;
      if (in_data.left) begin
         data_in.result = lshift[31:0] & in_data.mask;
         data_in.carry  = lcarry;
         if (in_data.cnt_ge_w) begin
            data_in.ovf = (in_data.value != 32'd0);
         end else begin
            data_in.ovf = (top != 32'd0) && (top != in_data.topmask);
         end
      end else begin
         data_in.result = rshift[32:1] & in_data.mask;
         data_in.carry  = rshift[0];
         data_in.ovf    = 1'b0;
      end
      data_in.kind       = in_data.kind;
      data_in.cnt_zero   = in_data.cnt_zero;
      data_in.mask       = in_data.mask;
      data_in.dst        = in_data.dst;
      data_in.dest_index = in_data.dest_index;
      data_in.x_in       = in_data.x_in;
      data_in.cycles     = in_data.cycles;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   `ASF_ASSERT(a_zero_count_quiet, valid_ff && data_ff.cnt_zero |-> !data_ff.carry && !data_ff.ovf, "zero count produced carry or overflow")
   `ASF_ASSERT(a_right_no_ovf, in_valid && in_ready && !in_data.left |=> !data_ff.ovf, "right shift produced overflow")
   `ASF_ASSERT(a_result_in_size, valid_ff |-> (data_ff.result & ~data_ff.mask) == 32'd0, "shift result exceeds operand size")

endmodule

### sv/asf_flags.sv
// ----------------------------------------------------------------------------
// Arithmetic shift with flags: flag stage
// Merges the kept upper bits and forms the X, N, Z, V and C flags.
// ----------------------------------------------------------------------------
module asf_flags (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  asf_pkg::shf_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output asf_pkg::rsp_type out_data
);
   import asf_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;

   always_comb begin
      case (in_data.kind)
         KIND_BYTE: data_in.flag_n = in_data.result[7];
         KIND_WORD: data_in.flag_n = in_data.result[15];
         default:   data_in.flag_n = in_data.result[31];
      endcase
      data_in.result_value = (in_data.dst & ~in_data.mask) | in_data.result;
      data_in.dest_index   = in_data.dest_index;
      data_in.flag_x       = in_data.cnt_zero ? in_data.x_in : in_data.carry;
      data_in.flag_z       = (in_data.result == 32'd0);
      data_in.flag_v       = in_data.ovf;
      data_in.flag_c       = in_data.carry;
      data_in.cycles       = in_data.cycles;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### tb/asf_shift_checker.sv
// ----------------------------------------------------------------------------
// Arithmetic shift with flags: result checker
// Watches both channels of the shifter. For every accepted request word it
// computes the expected register value, destination, flags and cycle cost,
// and compares each accepted response word against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module asf_shift_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  asf_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  asf_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import asf_pkg::*;

   rsp_type shifted_q[$];

   function automatic rsp_type predict_shift(input req_type w);
      int unsigned width;
      logic [31:0] mask;
      logic [31:0] opnd;
      logic [31:0] res;
      logic [31:0] top;
      logic [31:0] ones;
      logic [5:0]  cnt;
      logic [7:0]  base;
      logic        sign;
      logic        carry;
      logic        ovf;
      rsp_type     p;
      if (w.opcode[OP_REG_CNT_BIT]) begin
         cnt = w.count_register_low;
      end else begin
         cnt = {3'b000, w.opcode[OP_CNT_MSB:OP_CNT_LSB]};
         if (cnt == 6'd0) cnt = CNT_IMM_ZERO;
      end
      case (w.kind)
         KIND_BYTE: begin
            width = 8;
            mask = 32'h0000_00FF;
            base = BASE_SHORT;
         end
         KIND_WORD: begin
            width = 16;
            mask = 32'h0000_FFFF;
            base = BASE_SHORT;
         end
         default: begin
            width = 32;
            mask = 32'hFFFF_FFFF;
            base = BASE_LONG;
         end
      endcase
      opnd = w.destination_value & mask;
      sign = opnd[width - 1];
      res = opnd;
      carry = 1'b0;
      ovf = 1'b0;
      if (cnt != 6'd0) begin
         if (!w.opcode[OP_DIR_BIT]) begin
            if (cnt < width) begin
               res = opnd >> cnt;
               if (sign) res = res | (mask & ~(mask >> cnt));
               carry = opnd[cnt - 1];
            end else begin
               res = sign ? mask : 32'd0;
               carry = sign;
            end
         end else begin
            if (cnt < width) begin
               top = opnd >> (width - 1 - cnt);
               ones = mask >> (width - 1 - cnt);
               res = (opnd << cnt) & mask;
               carry = opnd[width - cnt];
               ovf = (top != 32'd0) && (top != ones);
            end else begin
               res = 32'd0;
               carry = (cnt == width) ? opnd[0] : 1'b0;
               ovf = (opnd != 32'd0);
            end
         end
      end
      p.result_value = (w.destination_value & ~mask) | res;
      p.dest_index = w.opcode[OP_DEST_MSB:0];
      p.flag_x = (cnt != 6'd0) ? carry : w.x_in;
      p.flag_n = res[width - 1];
      p.flag_z = (res == 32'd0);
      p.flag_v = ovf;
      p.flag_c = carry;
      p.cycles = base + 8'(2 * cnt);
      return p;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) shifted_q.push_back(predict_shift(req_data));
         if (rsp_valid && rsp_ready) begin
            if (shifted_q.size() == 0) begin
               $display("%0t: unexpected response word, actual %0h", $time, rsp_data);
               fail_count++;
            end else begin
               want = shifted_q.pop_front();
               check_field("result_value", want.result_value, rsp_data.result_value);
               check_field("dest_index", 32'(want.dest_index), 32'(rsp_data.dest_index));
               check_field("flag_x", 32'(want.flag_x), 32'(rsp_data.flag_x));
               check_field("flag_n", 32'(want.flag_n), 32'(rsp_data.flag_n));
               check_field("flag_z", 32'(want.flag_z), 32'(rsp_data.flag_z));
               check_field("flag_v", 32'(want.flag_v), 32'(rsp_data.flag_v));
               check_field("flag_c", 32'(want.flag_c), 32'(rsp_data.flag_c));
               check_field("cycles", 32'(want.cycles), 32'(rsp_data.cycles));
            end
         end
         pending = shifted_q.size();
      end
   end

endmodule

### tb/tb_arithmetic_shift_with_flags.sv
// ----------------------------------------------------------------------------
// Arithmetic shift with flags: testbench
// Drives directed corner cases of the shifter (zero counts, immediate count
// of eight, counts at and beyond the operand size, sign changes, the spare
// size code) and then random instruction words under three flow-control
// phases. A separate checker predicts and compares every response word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_arithmetic_shift_with_flags;
   import asf_pkg::*;

   localparam logic [1:0] KIND_LONG  = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int RANDOM_PER_PHASE = 375;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      req_idle_pct = 0;
   int      rsp_idle_pct = 0;

   always #6 clock = ~clock;

   arithmetic_shift_with_flags dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   asf_shift_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending(pending)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   function automatic req_type make_word(input logic [1:0] kind, input logic left,
                                         input logic use_reg, input logic [5:0] cnt,
                                         input logic [31:0] value, input logic x);
      req_type w;
      w.opcode = 16'($urandom);
      w.opcode[OP_DIR_BIT] = left;
      w.opcode[OP_REG_CNT_BIT] = use_reg;
      if (!use_reg) w.opcode[OP_CNT_MSB:OP_CNT_LSB] = cnt[2:0];
      w.kind = kind;
      w.count_register_low = use_reg ? cnt : 6'($urandom);
      w.destination_value = value;
      w.x_in = x;
      return w;
   endfunction

   function automatic req_type random_word();
      logic [1:0]  kind;
      logic        use_reg;
      logic [5:0]  cnt;
      logic [31:0] mask;
      logic [31:0] raw;
      logic [31:0] pat;
      int          width;
      int          s;
      kind = ($urandom_range(0, 15) == 0) ? KIND_SPARE : 2'($urandom_range(0, 2));
      width = (kind == KIND_BYTE) ? 8 : (kind == KIND_WORD) ? 16 : 32;
      mask = (width == 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
      use_reg = 1'($urandom_range(0, 1));
      if (!use_reg) cnt = 6'($urandom_range(0, 7));
      else if ($urandom_range(0, 2) == 0) cnt = 6'(width - 1 + $urandom_range(0, 2));
      else cnt = 6'($urandom_range(0, 63));
      raw = $urandom;
      case ($urandom_range(0, 3))
         0: pat = raw;
         1: begin
            s = $urandom_range(1, width);
            pat = (s == 32) ? raw : (({32{raw[s - 1]}} << s) | (raw & ((32'd1 << s) - 32'd1)));
         end
         2: pat = {32{raw[0]}};
         default: pat = 32'd1 << $urandom_range(0, width - 1);
      endcase
      return make_word(kind, 1'($urandom), use_reg, cnt,
                       ($urandom & ~mask) | (pat & mask), 1'($urandom));
   endfunction

   task automatic send_word(input req_type w);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_word(random_word());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 13;
      rsp_idle_pct <= 45;

      send_word(make_word(KIND_BYTE, 1'b0, 1'b1, 6'd0, 32'h1234_5680, 1'b1));
      send_word(make_word(KIND_BYTE, 1'b1, 1'b1, 6'd0, 32'h0000_0000, 1'b0));
      send_word(make_word(KIND_BYTE, 1'b0, 1'b0, 6'd0, 32'hFFFF_FF80, 1'b0));
      send_word(make_word(KIND_BYTE, 1'b1, 1'b1, 6'd8, 32'hA5A5_A501, 1'b0));
      send_word(make_word(KIND_BYTE, 1'b1, 1'b1, 6'd9, 32'h0000_0001, 1'b1));
      send_word(make_word(KIND_BYTE, 1'b1, 1'b0, 6'd1, 32'h0000_0040, 1'b0));
      send_word(make_word(KIND_BYTE, 1'b0, 1'b0, 6'd1, 32'hFFFF_FF81, 1'b0));
      send_word(make_word(KIND_WORD, 1'b0, 1'b1, 6'd15, 32'h0000_8000, 1'b0));
      send_word(make_word(KIND_WORD, 1'b0, 1'b1, 6'd16, 32'hFFFF_7FFF, 1'b1));
      send_word(make_word(KIND_WORD, 1'b1, 1'b1, 6'd16, 32'h0000_0001, 1'b0));
      send_word(make_word(KIND_WORD, 1'b1, 1'b1, 6'd63, 32'h0000_FFFF, 1'b1));
      send_word(make_word(KIND_WORD, 1'b1, 1'b0, 6'd7, 32'h0000_00FF, 1'b0));
      send_word(make_word(KIND_LONG, 1'b0, 1'b1, 6'd31, 32'h8000_0000, 1'b0));
      send_word(make_word(KIND_LONG, 1'b0, 1'b1, 6'd32, 32'h8000_0000, 1'b0));
      send_word(make_word(KIND_LONG, 1'b0, 1'b1, 6'd63, 32'h7FFF_FFFF, 1'b1));
      send_word(make_word(KIND_LONG, 1'b1, 1'b1, 6'd31, 32'h0000_0001, 1'b0));
      send_word(make_word(KIND_LONG, 1'b1, 1'b1, 6'd32, 32'hFFFF_FFFF, 1'b0));
      send_word(make_word(KIND_LONG, 1'b1, 1'b1, 6'd33, 32'hFFFF_FFFF, 1'b1));
      send_word(make_word(KIND_LONG, 1'b1, 1'b1, 6'd0, 32'h0000_0000, 1'b1));
      send_word(make_word(KIND_SPARE, 1'b1, 1'b0, 6'd3, 32'hFFFF_FFFF, 1'b0));
      send_word(make_word(KIND_SPARE, 1'b0, 1'b1, 6'd40, 32'h0000_0000, 1'b1));

      send_random(RANDOM_PER_PHASE);
      req_idle_pct = 45;
      rsp_idle_pct <= 13;
      send_random(RANDOM_PER_PHASE);
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      send_random(RANDOM_PER_PHASE);
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
